// ===== rtl/edfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-server dispatch package
// Shared widths, types and helper functions for the dispatch block.
// ----------------------------------------------------------------------------
package edfd_pkg;

  // Pool size and internal time width.
  localparam int MAX_SERVERS = 16;
  localparam int TIME_BITS   = 48;

  // Fixed field widths of the transactions.
  localparam int ARRIVAL_BITS   = 32;
  localparam int DURATION_BITS  = 32;
  localparam int TAG_BITS       = 18;
  localparam int INDEX_OUT_BITS = 4;
  localparam int TIME_OUT_BITS  = 48;
  localparam int COUNT_BITS     = 5;

  // Derived widths.
  localparam int SERVER_IDX_BITS = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int USED_BITS       = $clog2(MAX_SERVERS + 1);
  localparam int GROUP_SIZE      = 4;
  localparam int NUM_GROUPS      = (MAX_SERVERS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int CLAMP_BITS      = (TIME_BITS > ARRIVAL_BITS) ? TIME_BITS : ARRIVAL_BITS;
  localparam int SUM_BITS        = ((TIME_BITS > DURATION_BITS) ? TIME_BITS
                                                                : DURATION_BITS) + 1;

  // Queue between the front end and the dispatch engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int REG_IDX_BITS   = CFG_ADDR_BITS - 2;
  localparam logic [REG_IDX_BITS-1:0] REG_SERVER_COUNT = '0;
  localparam logic [COUNT_BITS-1:0]   SERVER_COUNT_RESET = COUNT_BITS'(16);

  typedef logic [TIME_BITS-1:0]       time_t;
  typedef logic [SERVER_IDX_BITS-1:0] server_idx_t;
  typedef logic [USED_BITS-1:0]       used_t;
  typedef logic [DURATION_BITS-1:0]   duration_t;
  typedef logic [TAG_BITS-1:0]        tag_t;

  localparam time_t TIME_MAX = '1;

  // One queued task, arrival already clamped to the time range.
  typedef struct packed {
    time_t     arrival;
    duration_t duration;
    tag_t      tag;
  } task_entry_t;

  // Clamp a raw arrival into the time range.
  function automatic time_t clamp_arrival(input logic [ARRIVAL_BITS-1:0] a);
    logic [CLAMP_BITS-1:0] wide;
    logic [CLAMP_BITS-1:0] limit;
    wide  = CLAMP_BITS'(a);
    limit = CLAMP_BITS'(TIME_MAX);
    if (wide > limit) begin
      return TIME_MAX;
    end
    return TIME_BITS'(wide);
  endfunction

  // Number of servers taking part; zero means one, large values cap at the pool.
  function automatic used_t servers_in_use(input logic [COUNT_BITS-1:0] c);
    if (c == '0) begin
      return USED_BITS'(1);
    end
    if (int'(c) > MAX_SERVERS) begin
      return USED_BITS'(MAX_SERVERS);
    end
    return USED_BITS'(c);
  endfunction

  // Saturating time plus duration.
  function automatic time_t sat_add(input time_t a, input duration_t d);
    logic [SUM_BITS-1:0] s;
    s = SUM_BITS'(a) + SUM_BITS'(d);
    if (s > SUM_BITS'(TIME_MAX)) begin
      return TIME_MAX;
    end
    return TIME_BITS'(s);
  endfunction

endpackage

// ===== rtl/edfd_ifs.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-server dispatch channel interfaces
// Valid/ready channels for incoming tasks and outgoing dispatch results.
// ----------------------------------------------------------------------------

// Task channel: one transaction carries one task.
interface edfd_task_if import edfd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ARRIVAL_BITS-1:0] arrival_time;
  logic [DURATION_BITS-1:0] duration;
  logic [TAG_BITS-1:0]     task_tag;

  modport source(output valid, arrival_time, duration, task_tag, input ready);
  modport sink(input valid, arrival_time, duration, task_tag, output ready);
endinterface

// Result channel: one transaction carries one dispatch decision.
interface edfd_result_if import edfd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [INDEX_OUT_BITS-1:0] server_index;
  logic [TAG_BITS-1:0]       task_tag_out;
  logic                      waited;
  logic [TIME_OUT_BITS-1:0]  start_time;
  logic [TIME_OUT_BITS-1:0]  finish_time;

  modport source(output valid, server_index, task_tag_out, waited, start_time,
                 finish_time, input ready);
  modport sink(input valid, server_index, task_tag_out, waited, start_time,
               finish_time, output ready);
endinterface

// ===== rtl/edfd_front.sv =====
// ----------------------------------------------------------------------------
// Dispatch front end
// Accepts task transactions, clamps the arrival time and holds them in a
// short queue for the dispatch engine.
// ----------------------------------------------------------------------------
module edfd_front import edfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  edfd_task_if.sink   tasks,
  output task_entry_t q_entry,
  output logic        q_valid,
  input  logic        q_ready
);

  task_entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;
  logic                   push;
  logic                   pop;

  // Handshake decode.
  assign tasks.ready = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign push        = tasks.valid && tasks.ready;
  assign q_valid     = (count != '0);
  assign pop         = q_valid && q_ready;
  assign q_entry     = slots[rd_ptr];

  // Queue storage; entries carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{arrival:  clamp_arrival(tasks.arrival_time),
                         duration: tasks.duration,
                         tag:      tasks.task_tag};
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

// ===== rtl/edfd_back.sv =====
// ----------------------------------------------------------------------------
// Dispatch engine
// Keeps the per-server finish times, finds the lowest free server or the
// earliest finishing busy one, updates it and registers the result.
// ----------------------------------------------------------------------------
module edfd_back import edfd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  used_t         n_used,
  input  task_entry_t   q_entry,
  input  logic          q_valid,
  output logic          q_ready,
  edfd_result_if.source results
);

  typedef enum logic [1:0] {
    S_SCAN,
    S_PICK,
    S_FIN
  } state_t;

  state_t      state;
  time_t       finish [MAX_SERVERS];

  // Scan stage registers.
  task_entry_t cur;
  logic        p_found;
  server_idx_t p_free_idx;
  time_t       g_best  [NUM_GROUPS];
  server_idx_t g_idx   [NUM_GROUPS];
  logic        g_valid [NUM_GROUPS];

  // Pick stage registers.
  time_t       f_start;
  server_idx_t f_chosen;
  logic        f_waited;

  // Output register.
  logic        out_valid;
  server_idx_t out_idx;
  tag_t        out_tag;
  logic        out_waited;
  time_t       out_start;
  time_t       out_finish;

  // Combinational results of each step.
  logic [MAX_SERVERS-1:0] used;
  logic [MAX_SERVERS-1:0] free;
  logic        scan_found;
  server_idx_t scan_free_idx;
  time_t       scan_best  [NUM_GROUPS];
  server_idx_t scan_idx   [NUM_GROUPS];
  logic        scan_valid [NUM_GROUPS];
  time_t       pick_start;
  server_idx_t pick_idx;
  logic        pick_any;
  time_t       fin_value;
  logic        fin_go;

  assign q_ready = (state == S_SCAN);

  // Free flags and the lowest-numbered free server.
  always_comb begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      used[i] = (USED_BITS'(i) < n_used);
      free[i] = used[i] && (finish[i] <= q_entry.arrival);
    end
    scan_found    = |free;
    scan_free_idx = '0;
    for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
      if (free[i]) begin
        scan_free_idx = SERVER_IDX_BITS'(i);
      end
    end
  end

  // First level of the minimum search: earliest finish within each group.
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      scan_best[g]  = '0;
      scan_idx[g]   = '0;
      scan_valid[g] = 1'b0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < MAX_SERVERS) begin
          if (used[g * GROUP_SIZE + k] &&
              (!scan_valid[g] || (finish[g * GROUP_SIZE + k] < scan_best[g]))) begin
            scan_best[g]  = finish[g * GROUP_SIZE + k];
            scan_idx[g]   = SERVER_IDX_BITS'(g * GROUP_SIZE + k);
            scan_valid[g] = 1'b1;
          end
        end
      end
    end
  end

  // Second level: earliest finish over the groups, or the free server.
  always_comb begin
    pick_start = '0;
    pick_idx   = '0;
    pick_any   = 1'b0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (g_valid[g] && (!pick_any || (g_best[g] < pick_start))) begin
        pick_start = g_best[g];
        pick_idx   = g_idx[g];
        pick_any   = 1'b1;
      end
    end
    if (p_found) begin
      pick_start = cur.arrival;
      pick_idx   = p_free_idx;
    end
  end

  // New finish time, committed once the output register can take it.
  assign fin_value = sat_add(f_start, cur.duration);
  assign fin_go    = !out_valid || results.ready;

  // Sequencer, finish times and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SCAN;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
        finish[i] <= '0;
      end
    end else begin
      // The result is loaded by a commit and cleared once it is taken.
      if ((state == S_FIN) && fin_go) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_SCAN: begin
          if (q_valid) begin
            cur        <= q_entry;
            p_found    <= scan_found;
            p_free_idx <= scan_free_idx;
            for (int g = 0; g < NUM_GROUPS; g++) begin
              g_best[g]  <= scan_best[g];
              g_idx[g]   <= scan_idx[g];
              g_valid[g] <= scan_valid[g];
            end
            state <= S_PICK;
          end
        end
        S_PICK: begin
          f_start  <= pick_start;
          f_chosen <= pick_idx;
          f_waited <= !p_found;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            finish[f_chosen] <= fin_value;
            out_idx          <= f_chosen;
            out_tag          <= cur.tag;
            out_waited       <= f_waited;
            out_start        <= f_start;
            out_finish       <= fin_value;
            state            <= S_SCAN;
          end
        end
        default: begin
          state <= S_SCAN;
        end
      endcase
    end
  end

  // Result channel.
  assign results.valid        = out_valid;
  assign results.server_index = INDEX_OUT_BITS'(out_idx);
  assign results.task_tag_out = out_tag;
  assign results.waited       = out_waited;
  assign results.start_time   = TIME_OUT_BITS'(out_start);
  assign results.finish_time  = TIME_OUT_BITS'(out_finish);

endmodule

// ===== rtl/earliest_free_server_dispatch.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-server dispatch
// Assigns each task to the lowest free server, or queues it on the server
// that finishes first, and reports the server, start and finish times.
//
//   Channel   Direction  Transaction
//   tasks     in         arrival_time, duration, task_tag
//   results   out        server_index, task_tag_out, waited, start_time,
//                        finish_time
//   APB       in/out     server_count register at byte address 0
//
// Each task passes through three steps in the dispatch engine: a free-flag and
// grouped minimum scan, a final minimum pick, and a saturating add that
// writes the chosen finish time back; the next task's scan needs that write.
// A two-entry queue accepts tasks until it is full while a result waits to be taken.
// Reset (synchronous) clears every finish time and sets server_count to 16.
// ----------------------------------------------------------------------------
module earliest_free_server_dispatch import edfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  edfd_task_if.sink                tasks,
  edfd_result_if.source            results,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [COUNT_BITS-1:0]   server_count;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    cfg_write;
  used_t                   n_used;
  task_entry_t             q_entry;
  logic                    q_valid;
  logic                    q_ready;

  // Register decode.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[CFG_ADDR_BITS-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= SERVER_COUNT_RESET;
    end else if (cfg_write && (reg_idx == REG_SERVER_COUNT)) begin
      server_count <= pwdata[COUNT_BITS-1:0];
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SERVER_COUNT) begin
      prdata = CFG_DATA_BITS'(server_count);
    end
  end

  assign n_used = servers_in_use(server_count);

  // Front end: accept and queue tasks.
  edfd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .tasks   (tasks),
    .q_entry (q_entry),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  // Back end: dispatch against the server finish times.
  edfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .n_used  (n_used),
    .q_entry (q_entry),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .results (results)
  );

`ifndef ASSERT_OFF
  // A result never names a server outside the pool in use.
  a_index_in_pool: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.server_index < n_used))
    else $error("dispatch result names a server outside the pool in use");

  // The new finish time never falls before the start time.
  a_finish_after_start: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> ((TIME_BITS > TIME_OUT_BITS) ||
                       (results.finish_time >= results.start_time)))
    else $error("dispatch finish time is before its start time");

  // A task that found a free server has a finish time no earlier than its start time.
  a_no_wait_when_idle: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.waited |-> (results.finish_time >= results.start_time))
    else $error("free-server dispatch has inconsistent times");
`endif

endmodule

// ===== tb/tb_earliest_free_server_dispatch.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-server dispatch testbench
// Drives tasks through the dispatch block under several server counts and
// handshake idling patterns. Each result is checked field by field against
// a local model that tracks every server's finish time. The run covers the
// register port, a long result stall, and long queues on a single server.
// ----------------------------------------------------------------------------
module tb_earliest_free_server_dispatch;
  import edfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SEGMENT_ITEMS  = 100;
  localparam int SAT_ITEMS      = 40;
  localparam int PRINT_LIMIT    = 40;

  // Expected content of one result transaction.
  typedef struct packed {
    logic [INDEX_OUT_BITS-1:0] server;
    tag_t                      tag;
    logic                      waited;
    logic [TIME_OUT_BITS-1:0]  start;
    logic [TIME_OUT_BITS-1:0]  finish;
  } dispatch_t;

  logic clk = 1'b0;
  logic rst;

  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  edfd_task_if   task_ch ();
  edfd_result_if res_ch ();

  earliest_free_server_dispatch i_dut (
    .clk     (clk),
    .rst     (rst),
    .tasks   (task_ch),
    .results (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model state: one finish time per server and the programmed count.
  time_t                 finish_model [MAX_SERVERS];
  logic [COUNT_BITS-1:0] count_model;

  dispatch_t pending_dispatch [$];

  int unsigned       error_count    = 0;
  int unsigned       tasks_sent     = 0;
  int unsigned       results_seen   = 0;
  int unsigned       queued_tasks   = 0;
  int unsigned       saturated_seen = 0;
  int unsigned       count_settings = 0;
  int                send_idle_pct  = 0;
  int                recv_idle_pct  = 0;
  int                hold_left      = 0;
  int                hold_requests  = 0;
  int                hold_served    = 0;
  logic [ARRIVAL_BITS-1:0] last_arrival = '0;

  // Clock with a period of four time units.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Prints one mismatch line while under the print limit, and counts it.
  task automatic report_mismatch(input string what, input tag_t tag,
                                 input logic [63:0] got, input logic [63:0] want);
    if (error_count < PRINT_LIMIT) begin
      $display("MISMATCH tag %0h %s: got %0h, expected %0h", tag, what, got, want);
    end
    error_count++;
  endtask

  // Works out the dispatch of one task and updates the model's finish times.
  function automatic dispatch_t dispatch_predict(input logic [ARRIVAL_BITS-1:0] arr,
                                                 input duration_t dur, input tag_t tag);
    int                 n;
    int                 pick;
    bit                 free_found;
    time_t              arrival;
    time_t              start_at;
    logic [TIME_BITS:0] sum;
    dispatch_t          r;
    n = (count_model == '0) ? 1 :
        ((int'(count_model) > MAX_SERVERS) ? MAX_SERVERS : int'(count_model));
    // A 32-bit arrival always fits the time range, so no clamping is needed.
    arrival    = time_t'(arr);
    pick       = 0;
    free_found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!free_found && finish_model[i] <= arrival) begin
        pick       = i;
        free_found = 1'b1;
      end
    end
    if (free_found) begin
      start_at = arrival;
    end else begin
      // Earliest finish among busy servers; the lowest index wins a tie.
      pick = 0;
      for (int i = 1; i < n; i++) begin
        if (finish_model[i] < finish_model[pick]) begin
          pick = i;
        end
      end
      start_at = finish_model[pick];
    end
    sum = {1'b0, start_at} + (TIME_BITS + 1)'(dur);
    finish_model[pick] = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_BITS-1:0];
    r.server = pick[INDEX_OUT_BITS-1:0];
    r.tag    = tag;
    r.waited = !free_found;
    r.start  = start_at[TIME_OUT_BITS-1:0];
    r.finish = finish_model[pick][TIME_OUT_BITS-1:0];
    return r;
  endfunction

  // Offers one task, waits for its transaction and records the expectation.
  task automatic send_task(input logic [ARRIVAL_BITS-1:0] arr, input duration_t dur,
                           input tag_t tag);
    if ($urandom_range(99) < send_idle_pct) begin
      task_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    task_ch.valid        <= 1'b1;
    task_ch.arrival_time <= arr;
    task_ch.duration     <= dur;
    task_ch.task_tag     <= tag;
    do @(posedge clk); while (!task_ch.ready);
    pending_dispatch.insert(pending_dispatch.size(), dispatch_predict(arr, dur, tag));
    last_arrival = arr;
    tasks_sent++;
  endtask

  // Builds one random task: mostly nondecreasing arrivals, with some noise.
  task automatic send_random(input int inc_max, input int dur_max);
    logic [ARRIVAL_BITS-1:0] arr;
    logic [ARRIVAL_BITS:0]   nxt;
    duration_t               dur;
    int                      pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      arr = $urandom();
    end else begin
      if (pick < 80) begin
        nxt = {1'b0, last_arrival} + (ARRIVAL_BITS + 1)'($urandom_range(0, inc_max));
      end else if (pick < 95) begin
        nxt = {1'b0, last_arrival} + (ARRIVAL_BITS + 1)'($urandom_range(0, 1 << 24));
      end else begin
        nxt = {1'b0, last_arrival} + (ARRIVAL_BITS + 1)'($urandom_range(0, 32'h7FFF_FFFF));
      end
      // Past the end of the arrival range the sequence restarts low.
      arr = nxt[ARRIVAL_BITS] ? ARRIVAL_BITS'($urandom_range(0, 1000)) :
                                nxt[ARRIVAL_BITS-1:0];
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      dur = duration_t'($urandom_range(0, dur_max));
    end else if (pick < 80) begin
      dur = '0;
    end else if (pick < 90) begin
      dur = '1;
    end else begin
      dur = $urandom();
    end
    send_task(arr, dur, tag_t'($urandom()));
  endtask

  // Stops offering tasks and waits until every expected result has come.
  task automatic drain_results;
    task_ch.valid <= 1'b0;
    while (pending_dispatch.size() != 0) @(posedge clk);
  endtask

  // One register port transfer; the select stays high for a following one.
  task automatic apb_xfer(input bit wr, input logic [CFG_DATA_BITS-1:0] wdata,
                          output logic [CFG_DATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_SERVER_COUNT, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) begin
      count_model = wdata[COUNT_BITS-1:0];
    end
  endtask

  // Reads the server count register and compares it with the model.
  task automatic check_server_count;
    logic [CFG_DATA_BITS-1:0] rd;
    apb_xfer(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[COUNT_BITS-1:0] !== count_model) begin
      report_mismatch("server_count readback", '0, 64'(rd[COUNT_BITS-1:0]),
                      64'(count_model));
    end
  endtask

  // Writes the server count, with random upper data bits, then reads it back.
  task automatic program_server_count(input logic [COUNT_BITS-1:0] cnt);
    logic [CFG_DATA_BITS-1:0] wdata;
    logic [CFG_DATA_BITS-1:0] rd;
    wdata = $urandom();
    wdata[COUNT_BITS-1:0] = cnt;
    apb_xfer(1'b1, wdata, rd);
    check_server_count();
    count_settings++;
  endtask

  // Register value after reset.
  task automatic test_reset_value;
    check_server_count();
  endtask

  // Free and busy servers, ties, odd counts, extremes and a falling arrival.
  task automatic test_directed;
    send_task(32'd0, 32'd0, 18'h00000);
    send_task(32'd0, 32'hFFFF_FFFF, 18'h3FFFF);
    send_task(32'd0, 32'd10, 18'h00001);
    send_task(32'd5, 32'd1, 18'h00002);
    drain_results();
    // Two servers, both busy: tasks queue on the earlier one.
    program_server_count(5'd2);
    send_task(32'd6, 32'd100, 18'h00003);
    send_task(32'd10, 32'd100, 18'h00004);
    drain_results();
    // A count of zero behaves as a single server.
    program_server_count(5'd0);
    send_task(32'd20, 32'd5, 18'h00005);
    drain_results();
    // Both servers end up with the same finish time, then a tie is broken.
    program_server_count(5'd2);
    send_task(32'd300, 32'hFFFF_FED8, 18'h00006);
    send_task(32'd400, 32'd7, 18'h00007);
    drain_results();
    // Counts above the pool size behave as the full pool.
    program_server_count(5'd31);
    send_task(32'd400, 32'd3, 18'h00008);
    send_task(32'h0000_FFFF, 32'h5555_5555, 18'h2AAAA);
    send_task(32'hFFFF_FFFF, 32'hAAAA_AAAA, 18'h15555);
    send_task(32'hFFFF_FFFF, 32'd1, 18'h00009);
    // Arrival falls back to zero.
    send_task(32'd0, 32'd2, 18'h0000A);
    drain_results();
    program_server_count(5'd16);
    send_task(32'h8000_0000, 32'd0, 18'h0000B);
    send_task(32'h8000_0000, 32'hFFFF_FFFF, 18'h0000C);
    drain_results();
  endtask

  // Random segments, each under its own server count.
  task automatic test_random(input int s_pct, input int r_pct);
    logic [COUNT_BITS-1:0] counts [6];
    int                    inc_max;
    counts = '{5'd1, 5'd2, 5'd16, 5'd0, 5'd31, 5'(COUNT_BITS'($urandom_range(1, 16)))};
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int s = 0; s < 6; s++) begin
      drain_results();
      program_server_count(counts[s]);
      inc_max = $urandom_range(1, 64);
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
        send_random(inc_max, inc_max * $urandom_range(1, 20));
      end
    end
    drain_results();
  endtask

  // The receiver stalls for a long stretch while tasks keep coming.
  task automatic test_backpressure;
    program_server_count(5'd3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    for (int i = 0; i < 40; i++) begin
      send_random(8, 60);
    end
    drain_results();
  endtask

  // One server and maximum durations build a long queue of waiting tasks.
  task automatic test_saturation;
    program_server_count(5'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < SAT_ITEMS; i++) begin
      send_task(32'hFFFF_FFFF, 32'hFFFF_FFFF, tag_t'(i));
    end
    drain_results();
  endtask

  // Result receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served  <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    dispatch_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (pending_dispatch.size() == 0) begin
        report_mismatch("result with nothing expected", res_ch.task_tag_out, '0, '0);
      end else begin
        want = pending_dispatch.pop_front();
        if (want.waited) queued_tasks++;
        if (want.finish == TIME_MAX[TIME_OUT_BITS-1:0]) saturated_seen++;
        if (res_ch.server_index !== want.server)
          report_mismatch("server_index", want.tag, 64'(res_ch.server_index),
                          64'(want.server));
        if (res_ch.task_tag_out !== want.tag)
          report_mismatch("task_tag_out", want.tag, 64'(res_ch.task_tag_out),
                          64'(want.tag));
        if (res_ch.waited !== want.waited)
          report_mismatch("waited", want.tag, 64'(res_ch.waited), 64'(want.waited));
        if (res_ch.start_time !== want.start)
          report_mismatch("start_time", want.tag, 64'(res_ch.start_time),
                          64'(want.start));
        if (res_ch.finish_time !== want.finish)
          report_mismatch("finish_time", want.tag, 64'(res_ch.finish_time),
                          64'(want.finish));
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no transaction.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((task_ch.valid && task_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence.
  initial begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      finish_model[i] = '0;
    end
    count_model = SERVER_COUNT_RESET;
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    task_ch.valid        <= 1'b0;
    task_ch.arrival_time <= '0;
    task_ch.duration     <= '0;
    task_ch.task_tag     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_value();
    test_directed();
    test_random(25, 63);
    test_random(63, 25);
    test_random(0, 0);
    test_backpressure();
    test_saturation();

    drain_results();
    repeat (16) @(posedge clk);
    $display("Dispatched %0d tasks under %0d server-count settings; %0d results checked.",
             tasks_sent, count_settings, results_seen);
    $display("%0d tasks queued on a busy server, %0d finish times saturated.",
             queued_tasks, saturated_seen);
    if (error_count == 0 && pending_dispatch.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/edfd_pkg.sv
rtl/edfd_ifs.sv
rtl/edfd_front.sv
rtl/edfd_back.sv
rtl/earliest_free_server_dispatch.sv
tb/tb_earliest_free_server_dispatch.sv
